// ===== sv/fla_pkg.sv =====
// Shared types and codes for the free-list pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package fla_pkg;

  // Action codes carried by the action field of an input item.
  typedef enum logic [2:0] {
    ACT_INIT  = 3'd0,
    ACT_ALLOC = 3'd1,
    ACT_FREE  = 3'd2,
    ACT_MARK  = 3'd3,
    ACT_SWEEP = 3'd4
  } action_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_SETUP,
    S_INIT_FILL,
    S_ALLOC_RD,
    S_ALLOC_UPD,
    S_FREE_RD,
    S_FREE_UPD,
    S_MARK,
    S_SWEEP_RD,
    S_SWEEP_UPD,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;        // latch the input item and clear the result fields
    logic init_start;  // latch the clamped pool size, clear the scan counter
    logic init_wr;     // write one entry of the initial chain
    logic init_end;    // set head, free total and active pool size
    logic alloc_upd;   // pop the head using the link read last cycle
    logic push;        // push an entry onto the free list
    logic push_cnt;    // the pushed entry is the scan counter, not the index
    logic reclaim;     // count one reclaimed entry
    logic mark_wr;     // set the mark bit of the indexed entry
    logic mark_clr;    // clear the mark bit of the scanned entry
    logic sweep_rd;    // read the flags of the scanned entry
    logic cnt_inc;     // advance the scan counter
    logic set_ok;      // the action succeeded
    logic load_out;    // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic list_empty;
    logic idx_in_pool;
    logic pool_empty;
    logic fill_last;
    logic sweep_last;
    logic rd_free;
    logic rd_mark;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/fla_ctrl.sv =====
// Controller state machine of the free-list pool allocator.
`timescale 1ns / 1ps
`default_nettype none

module fla_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [2:0]       action_i,
  input  wire fla_pkg::status_t status_i,
  output fla_pkg::cmd_t         cmd_o
);

  fla_pkg::state_e state_q, state_d;
  logic            boot_q, boot_d;

  // An item is taken only while the controller is idle.
  assign in_stall_o = (state_q != fla_pkg::S_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fla_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (fla_pkg::action_e'(action_i))
            fla_pkg::ACT_INIT:  state_d = fla_pkg::S_INIT_SETUP;
            fla_pkg::ACT_ALLOC: state_d = fla_pkg::S_ALLOC_RD;
            fla_pkg::ACT_FREE:  state_d = fla_pkg::S_FREE_RD;
            fla_pkg::ACT_MARK:  state_d = fla_pkg::S_MARK;
            fla_pkg::ACT_SWEEP: state_d = fla_pkg::S_SWEEP_RD;
            default:            state_d = fla_pkg::S_DONE;
          endcase
        end
      end
      fla_pkg::S_INIT_SETUP: state_d = fla_pkg::S_INIT_FILL;
      fla_pkg::S_INIT_FILL: begin
        if (status_i.fill_last) begin
          state_d = boot_q ? fla_pkg::S_IDLE : fla_pkg::S_DONE;
        end
      end
      fla_pkg::S_ALLOC_RD: begin
        state_d = status_i.list_empty ? fla_pkg::S_DONE : fla_pkg::S_ALLOC_UPD;
      end
      fla_pkg::S_ALLOC_UPD: state_d = fla_pkg::S_DONE;
      fla_pkg::S_FREE_RD: begin
        state_d = status_i.idx_in_pool ? fla_pkg::S_FREE_UPD : fla_pkg::S_DONE;
      end
      fla_pkg::S_FREE_UPD: state_d = fla_pkg::S_DONE;
      fla_pkg::S_MARK:     state_d = fla_pkg::S_DONE;
      fla_pkg::S_SWEEP_RD: begin
        state_d = status_i.pool_empty ? fla_pkg::S_DONE : fla_pkg::S_SWEEP_UPD;
      end
      fla_pkg::S_SWEEP_UPD: begin
        state_d = status_i.sweep_last ? fla_pkg::S_DONE : fla_pkg::S_SWEEP_RD;
      end
      fla_pkg::S_DONE: begin
        if (status_i.out_free) begin
          state_d = fla_pkg::S_IDLE;
        end
      end
      default: state_d = fla_pkg::S_IDLE;
    endcase
  end

  // The pass after reset builds the chain without producing a result item.
  always_comb begin
    boot_d = boot_q;
    if (state_q == fla_pkg::S_INIT_FILL && status_i.fill_last) begin
      boot_d = 1'b0;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      fla_pkg::S_IDLE: begin
        cmd_o.take = in_valid_i;
      end
      fla_pkg::S_INIT_SETUP: begin
        cmd_o.init_start = 1'b1;
      end
      fla_pkg::S_INIT_FILL: begin
        cmd_o.init_wr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.fill_last) begin
          cmd_o.init_end = 1'b1;
          cmd_o.set_ok   = !boot_q;
        end
      end
      fla_pkg::S_ALLOC_RD: begin
        cmd_o = '0;
      end
      fla_pkg::S_ALLOC_UPD: begin
        cmd_o.alloc_upd = 1'b1;
        cmd_o.set_ok    = 1'b1;
      end
      fla_pkg::S_FREE_RD: begin
        cmd_o = '0;
      end
      fla_pkg::S_FREE_UPD: begin
        // A double free is refused.
        if (!status_i.rd_free) begin
          cmd_o.push   = 1'b1;
          cmd_o.set_ok = 1'b1;
        end
      end
      fla_pkg::S_MARK: begin
        if (status_i.idx_in_pool) begin
          cmd_o.mark_wr = 1'b1;
          cmd_o.set_ok  = 1'b1;
        end
      end
      fla_pkg::S_SWEEP_RD: begin
        cmd_o.sweep_rd = 1'b1;
        cmd_o.set_ok   = status_i.pool_empty;
      end
      fla_pkg::S_SWEEP_UPD: begin
        // Entries that are neither marked nor free go back on the list.
        cmd_o.mark_clr = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (!(status_i.rd_mark || status_i.rd_free)) begin
          cmd_o.push     = 1'b1;
          cmd_o.push_cnt = 1'b1;
          cmd_o.reclaim  = 1'b1;
        end
        cmd_o.set_ok = status_i.sweep_last;
      end
      fla_pkg::S_DONE: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fla_pkg::S_INIT_SETUP;
      boot_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      boot_q  <= boot_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fla_datapath.sv =====
// Datapath of the free-list pool allocator: link and flag memories, list registers, output.
`timescale 1ns / 1ps
`default_nettype none

module fla_datapath #(
  parameter int unsigned POOL_DEPTH = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [8:0]    cfg_wdata_i,
  input  wire logic [7:0]    entry_index_i,
  input  wire fla_pkg::cmd_t cmd_i,
  output fla_pkg::status_t   status_o,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output logic [7:0]         granted_index_o,
  output logic               success_o,
  output logic [8:0]         reclaimed_count_o,
  output logic [8:0]         free_count_o
);

  localparam int unsigned IW = $clog2(POOL_DEPTH);
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

  // Memories.
  logic [IW-1:0] link_mem [POOL_DEPTH];
  logic          free_mem [POOL_DEPTH];
  logic          mark_mem [POOL_DEPTH];

  // Registers.
  logic [8:0]    pool_size_q, pool_size_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] active_q, active_d;
  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] head_q, head_d;
  logic [7:0]    idx_q, idx_d;
  logic [IW-1:0] granted_q, granted_d;
  logic [CW-1:0] reclaimed_q, reclaimed_d;
  logic          ok_q, ok_d;
  logic [IW-1:0] link_rd_q;
  logic          free_rd_q, mark_rd_q;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_granted_q, out_granted_d;
  logic          out_ok_q, out_ok_d;
  logic [8:0]    out_reclaimed_q, out_reclaimed_d;
  logic [8:0]    out_free_q, out_free_d;

  // Derived values.
  logic [CW-1:0] n_clamp;
  logic          n_nz;
  logic [IW-1:0] idx_e, cnt_e, push_e;
  logic [CW:0]   cnt_plus1;
  logic [IW-1:0] init_link;
  logic          out_free;

  // Memory write and read ports.
  logic          link_we, free_we, mark_we;
  logic [IW-1:0] link_wa, free_wa, mark_wa;
  logic [IW-1:0] link_wd;
  logic          free_wd, mark_wd;
  logic [IW-1:0] free_ra;

  assign n_clamp   = (32'(pool_size_q) > 32'(POOL_DEPTH)) ? CW'(POOL_DEPTH) : CW'(pool_size_q);
  assign n_nz      = (n_q != '0);
  assign idx_e     = IW'(idx_q);
  assign cnt_e     = cnt_q[IW-1:0];
  assign push_e    = cmd_i.push_cnt ? cnt_e : idx_e;
  assign cnt_plus1 = {1'b0, cnt_q} + 1'b1;
  assign init_link = (cnt_plus1 < {1'b0, n_q}) ? IW'(cnt_plus1) : '0;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Status to the controller.
  always_comb begin
    status_o             = '0;
    status_o.list_empty  = (total_q == '0);
    status_o.idx_in_pool = (32'(idx_q) < 32'(active_q));
    status_o.pool_empty  = (active_q == '0);
    status_o.fill_last   = !n_nz || (cnt_q == n_q - 1'b1);
    status_o.sweep_last  = (cnt_q == active_q - 1'b1);
    status_o.rd_free     = free_rd_q;
    status_o.rd_mark     = mark_rd_q;
    status_o.out_free    = out_free;
  end

  // Memory port selection.
  always_comb begin
    link_we = (cmd_i.init_wr && n_nz) || cmd_i.push;
    link_wa = cmd_i.push ? push_e : cnt_e;
    link_wd = cmd_i.push ? head_q : init_link;

    free_we = (cmd_i.init_wr && n_nz) || cmd_i.alloc_upd || cmd_i.push;
    priority if (cmd_i.push) begin
      free_wa = push_e;
    end else if (cmd_i.alloc_upd) begin
      free_wa = head_q;
    end else begin
      free_wa = cnt_e;
    end
    free_wd = !cmd_i.alloc_upd;

    mark_we = (cmd_i.init_wr && n_nz) || cmd_i.mark_wr || cmd_i.mark_clr;
    mark_wa = cmd_i.mark_wr ? idx_e : cnt_e;
    mark_wd = cmd_i.mark_wr;

    free_ra = cmd_i.sweep_rd ? cnt_e : idx_e;
  end

  // Memories with registered reads.
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    link_rd_q <= link_mem[head_q];
    free_rd_q <= free_mem[free_ra];
    mark_rd_q <= mark_mem[cnt_e];
  end

  // Free list and scan registers.
  always_comb begin
    pool_size_d = cfg_we_i ? cfg_wdata_i : pool_size_q;
    n_d         = cmd_i.init_start ? n_clamp : n_q;
    active_d    = cmd_i.init_end ? n_q : active_q;
    idx_d       = cmd_i.take ? entry_index_i : idx_q;

    priority if (cmd_i.init_end) begin
      head_d  = '0;
      total_d = n_q;
    end else if (cmd_i.alloc_upd) begin
      head_d  = link_rd_q;
      total_d = total_q - 1'b1;
    end else if (cmd_i.push) begin
      head_d  = push_e;
      total_d = total_q + 1'b1;
    end else begin
      head_d  = head_q;
      total_d = total_q;
    end

    priority if (cmd_i.take || cmd_i.init_start) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  // Result fields of the current item.
  always_comb begin
    priority if (cmd_i.take) begin
      granted_d   = '0;
      reclaimed_d = '0;
      ok_d        = 1'b0;
    end else begin
      granted_d   = cmd_i.alloc_upd ? head_q : granted_q;
      reclaimed_d = cmd_i.reclaim ? reclaimed_q + 1'b1 : reclaimed_q;
      ok_d        = ok_q || cmd_i.set_ok;
    end
  end

  // Output register: a loaded item stays until the receiver takes it.
  always_comb begin
    out_valid_d     = cmd_i.load_out || (out_valid_q && out_stall_i);
    out_granted_d   = cmd_i.load_out ? 8'(granted_q) : out_granted_q;
    out_ok_d        = cmd_i.load_out ? ok_q : out_ok_q;
    out_reclaimed_d = cmd_i.load_out ? 9'(reclaimed_q) : out_reclaimed_q;
    out_free_d      = cmd_i.load_out ? 9'(total_q) : out_free_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= 9'd256;
      active_q    <= '0;
      total_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pool_size_q <= pool_size_d;
      active_q    <= active_d;
      total_q     <= total_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    n_q             <= n_d;
    cnt_q           <= cnt_d;
    idx_q           <= idx_d;
    granted_q       <= granted_d;
    reclaimed_q     <= reclaimed_d;
    ok_q            <= ok_d;
    out_granted_q   <= out_granted_d;
    out_ok_q        <= out_ok_d;
    out_reclaimed_q <= out_reclaimed_d;
    out_free_q      <= out_free_d;
  end

  assign out_valid_o       = out_valid_q;
  assign granted_index_o   = out_granted_q;
  assign success_o         = out_ok_q;
  assign reclaimed_count_o = out_reclaimed_q;
  assign free_count_o      = out_free_q;

  // The free list never holds more entries than the active pool.
  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= active_q)
    else $error("free total exceeds active pool size");

  // A pop only happens on a non-empty list.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_upd |-> (total_q != '0))
    else $error("pop from an empty free list");

  // A push never overfills the list.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (total_q < active_q))
    else $error("push onto a full free list");

  // The output register is loaded only when it is empty or being drained.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

// ===== sv/free_list_pool_allocator.sv =====
// Top level of the free-list pool allocator with mark-and-sweep reclaim.
//
// Input channel: in_valid_i / in_stall_o with action_i and entry_index_i.
// Output channel: out_valid_o / out_stall_i with granted_index_o, success_o,
// reclaimed_count_o and free_count_o. Every input item gives one result item.
// Configuration: cfg_we_i writes cfg_wdata_i into the pool size, which is
// applied by the next init action; write it only while the block is idle.
//
// One item is in work at a time. Unknown actions go straight to the output
// register; mark writes its flag; alloc and free do a registered read of the
// link or flag memory, then the update, which is skipped for an empty list or
// an index out of the pool. Init sets up, then writes the chain entry by entry;
// sweep scans the active pool, unless it is empty, and visits one entry per
// read-then-update pair. The next item is accepted in the cycle after the result is loaded.
//
// After reset the block builds the chain for a pool of min(256, POOL_DEPTH)
// entries and accepts no item meanwhile.
// While the receiver stalls, the result is held and the block waits before
// loading the next one; in_stall_o stays high until it is loaded.
`timescale 1ns / 1ps
`default_nettype none

module free_list_pool_allocator #(
  parameter int unsigned POOL_DEPTH = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [8:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] action_i,
  input  wire logic [7:0] entry_index_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      granted_index_o,
  output logic            success_o,
  output logic [8:0]      reclaimed_count_o,
  output logic [8:0]      free_count_o
);

  fla_pkg::cmd_t    cmd;
  fla_pkg::status_t status;

  // Sequencer for the actions.
  fla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Pool storage, list registers and output register.
  fla_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .entry_index_i     (entry_index_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .granted_index_o   (granted_index_o),
    .success_o         (success_o),
    .reclaimed_count_o (reclaimed_count_o),
    .free_count_o      (free_count_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/fla_alloc_checker.sv =====
// Checker that predicts and compares the result items of the pool allocator.
`timescale 1ns / 1ps

module fla_alloc_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [2:0] action_i,
  input  logic [7:0] entry_index_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] granted_index_i,
  input  logic       success_i,
  input  logic [8:0] reclaimed_count_i,
  input  logic [8:0] free_count_i,
  output int         pending_o,
  output int         err_count_o
);

  localparam int unsigned ENTRIES = 256;

  // One predicted result item.
  typedef struct packed {
    logic [7:0] granted;
    logic       ok;
    logic [8:0] reclaimed;
    logic [8:0] free_cnt;
  } alloc_result_t;

  // Mirror of the pool: size register, active size, free list and flags.
  logic [8:0]    size_reg;
  logic [8:0]    active_n;
  logic [8:0]    list_head;
  logic [8:0]    list_len;
  logic [8:0]    link_q [ENTRIES];
  logic          mark_q [ENTRIES];
  logic          on_list [ENTRIES];
  alloc_result_t expected_q [$];
  int            fail_total = 0;

  // Put one entry on top of the free list.
  function automatic void push_free(input logic [8:0] e);
    link_q[e]  = list_head;
    list_head  = e;
    on_list[e] = 1'b1;
    list_len   = list_len + 9'd1;
  endfunction

  // Rebuild the ascending chain for the clamped pool size.
  function automatic void rebuild_pool();
    logic [8:0] n;
    n = (size_reg > 9'(ENTRIES)) ? 9'(ENTRIES) : size_reg;
    active_n = n;
    for (int i = 0; i < ENTRIES; i++) begin
      mark_q[i]  = 1'b0;
      on_list[i] = 1'b0;
      link_q[i]  = '0;
    end
    for (int i = 0; i < n; i++) begin
      link_q[i]  = (i + 1 < n) ? 9'(i + 1) : 9'd0;
      on_list[i] = 1'b1;
    end
    list_head = '0;
    list_len  = n;
  endfunction

  // Apply one input item to the mirror and return the result it causes.
  function automatic alloc_result_t apply_action(input logic [2:0] act,
                                                 input logic [7:0] idx);
    alloc_result_t r;
    r = '0;
    case (act)
      fla_pkg::ACT_INIT: begin
        rebuild_pool();
        r.ok = 1'b1;
      end
      fla_pkg::ACT_ALLOC: begin
        if (list_len != 0) begin
          r.granted          = list_head[7:0];
          list_head          = link_q[r.granted];
          on_list[r.granted] = 1'b0;
          list_len           = list_len - 9'd1;
          r.ok               = 1'b1;
        end
      end
      fla_pkg::ACT_FREE: begin
        if ({1'b0, idx} < active_n && !on_list[idx]) begin
          push_free({1'b0, idx});
          r.ok = 1'b1;
        end
      end
      fla_pkg::ACT_MARK: begin
        if ({1'b0, idx} < active_n) begin
          mark_q[idx] = 1'b1;
          r.ok        = 1'b1;
        end
      end
      fla_pkg::ACT_SWEEP: begin
        // Free entries count as marked; every unmarked entry in use is reclaimed.
        for (int i = 0; i < active_n; i++) begin
          if (mark_q[i] || on_list[i]) begin
            mark_q[i] = 1'b0;
          end else begin
            push_free(9'(i));
            r.reclaimed = r.reclaimed + 9'd1;
          end
        end
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.free_cnt = list_len;
    return r;
  endfunction

  // Report one field that differs from its prediction.
  function automatic int field_diff(input string name, input logic [8:0] want_v,
                                    input logic [8:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  // Watch the channels: results are checked before the new item is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      size_reg = 9'd256;
      rebuild_pool();
      expected_q.delete();
      pending_o   <= 0;
      err_count_o <= fail_total;
    end else begin
      if (cfg_we_i) begin
        size_reg = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result item with no item outstanding: granted_index %0d",
                 granted_index_i);
          fail_total++;
        end else begin
          want = expected_q.pop_front();
          fail_total += field_diff("granted_index", {1'b0, want.granted},
                                   {1'b0, granted_index_i});
          fail_total += field_diff("success", {8'd0, want.ok}, {8'd0, success_i});
          fail_total += field_diff("reclaimed_count", want.reclaimed,
                                   reclaimed_count_i);
          fail_total += field_diff("free_count", want.free_cnt, free_count_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(apply_action(action_i, entry_index_i));
      end
      pending_o   <= expected_q.size();
      err_count_o <= fail_total;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the pool allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned IDLE_PCT = 24;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 52;

  // Codes outside the defined actions.
  localparam logic [2:0] ACT_SPARE_A = 3'd5;
  localparam logic [2:0] ACT_SPARE_B = 3'd6;
  localparam logic [2:0] ACT_SPARE_C = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] action = '0;
  logic [7:0] entry_index = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] granted_index;
  logic       success;
  logic [8:0] reclaimed_count;
  logic [8:0] free_count;
  logic       quiet = 1'b0;
  int         pending;
  int         fail_count;

  free_list_pool_allocator DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .action_i         (action),
    .entry_index_i    (entry_index),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .granted_index_o  (granted_index),
    .success_o        (success),
    .reclaimed_count_o(reclaimed_count),
    .free_count_o     (free_count)
  );

  fla_alloc_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .action_i         (action),
    .entry_index_i    (entry_index),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .granted_index_i  (granted_index),
    .success_i        (success),
    .reclaimed_count_i(reclaimed_count),
    .free_count_i     (free_count),
    .pending_o        (pending),
    .err_count_o      (fail_count)
  );

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #10_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // The receiver stalls at random except during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Present one item after a random gap and hold it until it is accepted.
  task automatic send_item(input logic [2:0] act, input logic [7:0] idx);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    entry_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Let all results drain, then write the pool size register.
  task automatic write_pool_size(input logic [8:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Draw one item, weighted toward alloc, free and mark within the pool.
  task automatic random_item(input int unsigned size);
    int unsigned pick;
    int unsigned lim;
    logic [2:0]  act;
    logic [7:0]  idx;
    pick = $urandom_range(99);
    lim  = (size > 255) ? 255 : size;
    if (pick < 40) act = fla_pkg::ACT_ALLOC;
    else if (pick < 64) act = fla_pkg::ACT_FREE;
    else if (pick < 84) act = fla_pkg::ACT_MARK;
    else if (pick < 93) act = fla_pkg::ACT_SWEEP;
    else if (pick < 96) act = fla_pkg::ACT_INIT;
    else act = 3'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
    idx = ($urandom_range(9) < 7) ? 8'($urandom_range(0, lim)) : 8'($urandom);
    send_item(act, idx);
  endtask

  // Main sequence: reset, directed items, random phases, drain and verdict.
  initial begin
    int unsigned size;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Default pool: pops, double free, marks, sweep and unknown actions.
    send_item(fla_pkg::ACT_ALLOC, 8'd0);
    send_item(fla_pkg::ACT_ALLOC, 8'd0);
    send_item(fla_pkg::ACT_ALLOC, 8'd0);
    send_item(fla_pkg::ACT_FREE, 8'd1);
    send_item(fla_pkg::ACT_FREE, 8'd1);
    send_item(fla_pkg::ACT_MARK, 8'd0);
    send_item(fla_pkg::ACT_MARK, 8'd200);
    send_item(fla_pkg::ACT_MARK, 8'd255);
    send_item(fla_pkg::ACT_SWEEP, 8'd0);
    send_item(ACT_SPARE_A, 8'd255);
    send_item(ACT_SPARE_B, 8'd0);
    send_item(ACT_SPARE_C, 8'd255);

    // Empty pool: every alloc fails and every index is out of the pool.
    write_pool_size(9'd0);
    send_item(fla_pkg::ACT_INIT, 8'd0);
    send_item(fla_pkg::ACT_ALLOC, 8'd0);
    send_item(fla_pkg::ACT_FREE, 8'd0);
    send_item(fla_pkg::ACT_MARK, 8'd0);
    send_item(fla_pkg::ACT_SWEEP, 8'd0);

    // Oversized pool size is clamped to the full pool.
    write_pool_size(9'd511);
    send_item(fla_pkg::ACT_INIT, 8'd0);
    send_item(fla_pkg::ACT_ALLOC, 8'd0);

    // Tiny pool: run the free list dry, free out of range, reclaim all.
    write_pool_size(9'd3);
    send_item(fla_pkg::ACT_INIT, 8'd0);
    repeat (4) send_item(fla_pkg::ACT_ALLOC, 8'd0);
    send_item(fla_pkg::ACT_FREE, 8'd3);
    send_item(fla_pkg::ACT_SWEEP, 8'd0);

    // Random phases: mostly small pools, one full pool and one oversized.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) size = 1;
      else if (p == 3) size = 256;
      else if (p == 7) size = $urandom_range(257, 511);
      else size = $urandom_range(2, 24);
      write_pool_size(9'(size));
      quiet <= (p == 5);
      if (p == 0 || $urandom_range(9) != 0) send_item(fla_pkg::ACT_INIT, 8'($urandom));
      for (int k = 0; k < ((p == 3) ? 40 : PHASE_ITEMS); k++) begin
        random_item(size);
      end
    end

    // Drain the last results and give the verdict.
    in_valid <= 1'b0;
    quiet    <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
